// ===== sv/command_token_matcher_core_defines.svh =====
// Assertion macros shared by the checker of the command token matcher.
// Depends on nothing; the including file provides i_clk and i_rst_n.
`ifndef COMMAND_TOKEN_MATCHER_CORE_DEFINES_SVH
`define COMMAND_TOKEN_MATCHER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ctm_pkg.sv =====
// Package of the command token matcher: codes, defaults, result types and port layout.
// Depends on nothing; used by every module of the block and by its checker.
package ctm_pkg;

    localparam int DEF_BUFFER_BYTES = 64;
    localparam int DEF_NAME_CHARS   = 8;
    localparam int DEF_NAME_SLOTS   = 4;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int TEXT_BYTES  = 8;

    localparam logic [7:0] RST_END_CHAR  = 8'd59;
    localparam logic [7:0] RST_CMD_SEP   = 8'd44;
    localparam logic [7:0] RST_ARG_SEP   = 8'd32;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_LF       = 8'd10;
    localparam logic [6:0] LENGTH_MAX    = 7'd64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output tdata layout.
    localparam int OUT_TDATA_W  = 80;
    localparam int POS_TEXT     = 0;
    localparam int POS_LENGTH   = 64;
    localparam int POS_FOUND    = 71;
    localparam int POS_INDEX    = 72;
    localparam int POS_DROPPED  = 74;
    localparam int PAD_W        = OUT_TDATA_W - POS_DROPPED - 1;

    typedef enum logic [1:0] {
        KIND_COMMAND  = 2'd0,
        KIND_ARGUMENT = 2'd1,
        KIND_END      = 2'd2
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_END_CHAR      = 3'd0,
        CFG_CMD_SEP       = 3'd1,
        CFG_ARG_SEP       = 3'd2,
        CFG_COMMAND_COUNT = 3'd3,
        CFG_NAME_0        = 3'd4,
        CFG_NAME_1        = 3'd5,
        CFG_NAME_2        = 3'd6,
        CFG_NAME_3        = 3'd7
    } t_cfg_index;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] text;
        logic [6:0]  length;
        logic        found;
        logic [1:0]  index;
        logic        dropped;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== sv/ctm_tokenizer.sv =====
// Configuration registers, tokenizer state and per-item step with name matching.
// Depends on ctm_pkg; produces up to two result items for the result queue.
module ctm_tokenizer import ctm_pkg::*; #(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int NAME_CHARS   = DEF_NAME_CHARS,
    parameter int NAME_SLOTS   = DEF_NAME_SLOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    output t_push                  o_push
);

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int NAME_W = NAME_CHARS * 8;

    logic [7:0]        r_end_char;
    logic [7:0]        r_cmd_sep;
    logic [7:0]        r_arg_sep;
    logic [2:0]        r_command_count;
    logic [NAME_W-1:0] r_name [NAME_SLOTS];

    logic [63:0]       r_chars, n_chars;
    logic [6:0]        r_count, n_count;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_in_args, n_in_args;
    logic              r_overflowed, n_overflowed;

    logic [NAME_SLOTS-1:0] slot_hit;
    logic                  any_hit;
    logic [1:0]            hit_index;
    t_result               tok_res;
    t_result               end_res;

    function automatic logic name_equal(input logic [63:0] tok, input logic [NAME_W-1:0] name);
        logic eq;
        logic stop;
        eq   = 1'b1;
        stop = 1'b0;
        for (int j = 0; j < NAME_CHARS; j++) begin
            if (!stop) begin
                if (tok[8*j +: 8] != name[8*j +: 8]) begin
                    eq   = 1'b0;
                    stop = 1'b1;
                end else if (tok[8*j +: 8] == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
        return eq;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_char      <= RST_END_CHAR;
            r_cmd_sep       <= RST_CMD_SEP;
            r_arg_sep       <= RST_ARG_SEP;
            r_command_count <= 3'd0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_END_CHAR:      r_end_char      <= i_cfg_data[7:0];
                CFG_CMD_SEP:       r_cmd_sep       <= i_cfg_data[7:0];
                CFG_ARG_SEP:       r_arg_sep       <= i_cfg_data[7:0];
                CFG_COMMAND_COUNT: r_command_count <= i_cfg_data[2:0];
                CFG_NAME_0, CFG_NAME_1, CFG_NAME_2, CFG_NAME_3: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NAME_SLOTS; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_name[g] <= '0;
            end else if (i_cfg_wr_en &&
                         i_cfg_index == 3'(CFG_NAME_0) + 3'(g)) begin
                r_name[g] <= i_cfg_data[NAME_W-1:0];
            end
        end

        assign slot_hit[g] = (3'(g) < r_command_count) && name_equal(r_chars, r_name[g]);
    end

    always_comb begin
        any_hit   = |slot_hit;
        hit_index = 2'd0;
        for (int g = NAME_SLOTS - 1; g >= 0; g--) begin
            if (slot_hit[g]) begin
                hit_index = 2'(g);
            end
        end
    end

    always_comb begin
        tok_res.kind    = r_in_args ? KIND_ARGUMENT : KIND_COMMAND;
        tok_res.text    = r_chars;
        tok_res.length  = r_count;
        tok_res.found   = !r_in_args && any_hit;
        tok_res.index   = r_in_args ? 2'd0 : hit_index;
        tok_res.dropped = r_overflowed;
        tok_res.last    = 1'b0;

        end_res.kind    = KIND_END;
        end_res.text    = '0;
        end_res.length  = '0;
        end_res.found   = 1'b0;
        end_res.index   = 2'd0;
        end_res.dropped = r_overflowed;
        end_res.last    = 1'b1;
    end

    always_comb begin
        n_chars      = r_chars;
        n_count      = r_count;
        n_fill       = r_fill;
        n_in_args    = r_in_args;
        n_overflowed = r_overflowed;
        o_push.count = 2'd0;
        o_push.res0  = tok_res;
        o_push.res1  = end_res;

        if (i_step) begin
            if (i_byte == BYTE_CR || i_byte == BYTE_LF) begin
                n_chars = r_chars;
            end else if (i_byte == r_end_char) begin
                if (r_in_args || r_count != 7'd0) begin
                    o_push.count = 2'd2;
                end else begin
                    o_push.count = 2'd1;
                    o_push.res0  = end_res;
                end
                n_chars      = '0;
                n_count      = '0;
                n_fill       = '0;
                n_in_args    = 1'b0;
                n_overflowed = 1'b0;
            end else if (r_fill >= FILL_W'(BUFFER_BYTES)) begin
                n_overflowed = 1'b1;
            end else begin
                n_fill = r_fill + 1'b1;
                if (i_byte == r_cmd_sep) begin
                    if (r_count != 7'd0) begin
                        o_push.count     = 2'd1;
                        o_push.res0.last = 1'b1;
                        n_chars          = '0;
                        n_count          = '0;
                    end
                    n_in_args = 1'b0;
                end else if (i_byte == r_arg_sep) begin
                    if (r_in_args || r_count != 7'd0) begin
                        o_push.count     = 2'd1;
                        o_push.res0.last = 1'b1;
                        n_chars          = '0;
                        n_count          = '0;
                        n_in_args        = 1'b1;
                    end
                end else begin
                    if (r_count < 7'(TEXT_BYTES)) begin
                        n_chars[8*r_count[2:0] +: 8] = i_byte;
                    end
                    if (r_count < LENGTH_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars      <= '0;
            r_count      <= '0;
            r_fill       <= '0;
            r_in_args    <= 1'b0;
            r_overflowed <= 1'b0;
        end else begin
            r_chars      <= n_chars;
            r_count      <= n_count;
            r_fill       <= n_fill;
            r_in_args    <= n_in_args;
            r_overflowed <= n_overflowed;
        end
    end

endmodule

// ===== sv/ctm_result_queue.sv =====
// Four-entry result queue that takes up to two result items a cycle and gives one.
// Depends on ctm_pkg for the result types and the queue depth.
module ctm_result_queue import ctm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_item,
    input  logic    i_ready
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              pop;

    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];
    assign o_room  = r_cnt <= QCNT_W'(QUEUE_DEPTH - 2);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[QPTR_W'(r_wr + 1'b1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(i_push.count);
            r_rd  <= r_rd + QPTR_W'(pop);
            r_cnt <= r_cnt + QCNT_W'(i_push.count) - QCNT_W'(pop);
        end
    end

endmodule

// ===== sv/command_token_matcher_core.sv =====
// Top level of the command token matcher: input register, tokenizer and result queue.
// Depends on ctm_pkg, ctm_tokenizer and ctm_result_queue.
//
// Received bytes enter on the s_axis channel, one byte an item in tdata[7:0].
// Result items leave on the m_axis channel: tuser carries the token kind, tlast
// marks the final item caused by one byte, and tdata carries the token text, the
// token length, the match flag, the match index and the dropped-bytes flag.
// The configuration port writes one register per cycle; the user must write it only
// while the block is idle; the block does not enforce this. A byte is held in an
// input register until it is processed. One byte is accepted every cycle while the
// queue has room; a terminator that closes a pending token causes two result items,
// which leave one per cycle when the receiver is ready, through a four-entry queue.
// A byte is processed only when the queue has room for two items; when the
// receiver stalls, the queue fills, the byte waits in the input register and
// s_axis_tready falls. Reset restores the default separators, clears the names,
// the command count and the token state, and empties the queue.
module command_token_matcher_core import ctm_pkg::*; #(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int NAME_CHARS   = DEF_NAME_CHARS,
    parameter int NAME_SLOTS   = DEF_NAME_SLOTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // token_text, token_length, match_found, match_index, bytes_dropped, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // token_kind
    output logic                   m_axis_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       step;
    t_push      push;
    t_result    item;

    assign step          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    ctm_tokenizer #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .NAME_CHARS   (NAME_CHARS),
        .NAME_SLOTS   (NAME_SLOTS)
    ) u_tokenizer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_push      (push)
    );

    ctm_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_item  (item),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {PAD_W'(0), item.dropped, item.index, item.found,
                           item.length, item.text};
    assign m_axis_tuser = item.kind;
    assign m_axis_tlast = item.last;

endmodule

// ===== sv/ctm_checker.sv =====
// Port-level checker for the command token matcher, bound to the top level.
// Depends on ctm_pkg and on the assertion macros in the defines header.
`include "command_token_matcher_core_defines.svh"

module ctm_checker import ctm_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser,
    input logic                   m_axis_tlast
);

    `CTM_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tuser == KIND_END,
        m_axis_tlast, "End item without tlast.")

    `CTM_ASSERT_NOW(a_match_only_cmd, m_axis_tvalid && m_axis_tuser != KIND_COMMAND,
        !m_axis_tdata[POS_FOUND] && m_axis_tdata[POS_INDEX +: 2] == 2'd0,
        "Match fields set on an item that is not a command.")

    `CTM_ASSERT_NOW(a_end_empty, m_axis_tvalid && m_axis_tuser == KIND_END,
        m_axis_tdata[POS_LENGTH +: 7] == 7'd0 && m_axis_tdata[POS_TEXT +: 64] == 64'd0,
        "End item carries token text or length.")

    `CTM_ASSERT_NOW(a_length_sat, m_axis_tvalid,
        m_axis_tdata[POS_LENGTH +: 7] <= LENGTH_MAX, "Token length beyond its saturation value.")

    `CTM_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "Stalled result item changed.")

endmodule

bind command_token_matcher_core ctm_checker u_ctm_checker (.*);

// ===== test/command_token_matcher_core_tb.sv =====
// Self-checking testbench of command_token_matcher_core: bytes go in on the s_axis side and
// token items are predicted and compared on the m_axis side, under random sender and receiver
// pauses. Depends on ctm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module command_token_matcher_core_tb;
    import ctm_pkg::*;

    localparam int BUF_BYTES     = DEF_BUFFER_BYTES;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_QUARTER,
        RX_SPARSE
    } t_stall;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // token_text, token_length, match_found, match_index, bytes_dropped, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;         // token_kind
    logic                   m_axis_tlast;

    // Configuration and token state as the block should hold them.
    logic [7:0]  end_char;
    logic [7:0]  cmd_sep;
    logic [7:0]  arg_sep;
    logic [2:0]  name_count;
    logic [63:0] names [4];
    logic [63:0] tok_text;
    logic [6:0]  tok_len;
    int          fill_used;
    bit          in_args;
    bit          overflowed;

    t_result expected_tokens [$];
    int      errors      = 0;
    int      items_sent  = 0;
    int      burst_left  = 0;
    int      cycle_count = 0;
    t_stall  rx_mode     = RX_OPEN;
    int      rx_mode_left = 0;
    logic [3:0] rx_tick  = '0;

    command_token_matcher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] pack_name(input string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < TEXT_BYTES; i++) begin
            v[8*i +: 8] = s[i];
        end
        return v;
    endfunction

    // Closes the pending token and looks it up in the name table when it is a command.
    function automatic t_result close_token();
        t_result r;
        int      slots;
        bit      eq;
        bit      stop;
        r = '0;
        r.kind = in_args ? KIND_ARGUMENT : KIND_COMMAND;
        r.text = tok_text;
        r.length = tok_len;
        r.dropped = overflowed;
        if (!in_args) begin
            slots = (name_count > DEF_NAME_SLOTS) ? DEF_NAME_SLOTS : name_count;
            for (int i = 0; i < slots; i++) begin
                if (!r.found) begin
                    eq = 1'b1;
                    stop = 1'b0;
                    for (int j = 0; j < DEF_NAME_CHARS; j++) begin
                        if (!stop) begin
                            if (tok_text[8*j +: 8] != names[i][8*j +: 8]) begin
                                eq = 1'b0;
                                stop = 1'b1;
                            end else if (tok_text[8*j +: 8] == 8'd0) begin
                                stop = 1'b1;
                            end
                        end
                    end
                    if (eq) begin
                        r.found = 1'b1;
                        r.index = 2'(i);
                    end
                end
            end
        end
        tok_text = '0;
        tok_len = '0;
        return r;
    endfunction

    task automatic tokenize_byte(input logic [7:0] b);
        t_result res [2];
        int      n;
        n = 0;
        if (b == BYTE_CR || b == BYTE_LF) begin
            return;
        end
        if (b == end_char) begin
            if (in_args || tok_len != 0) begin
                res[n] = close_token();
                n++;
            end
            res[n] = '0;
            res[n].kind = KIND_END;
            res[n].dropped = overflowed;
            n++;
            tok_text = '0;
            tok_len = '0;
            fill_used = 0;
            in_args = 1'b0;
            overflowed = 1'b0;
        end else if (fill_used >= BUF_BYTES) begin
            overflowed = 1'b1;
        end else begin
            fill_used++;
            if (b == cmd_sep) begin
                if (tok_len != 0) begin
                    res[n] = close_token();
                    n++;
                end
                in_args = 1'b0;
            end else if (b == arg_sep) begin
                if (in_args || tok_len != 0) begin
                    res[n] = close_token();
                    n++;
                    in_args = 1'b1;
                end
            end else begin
                if (tok_len < TEXT_BYTES) begin
                    tok_text[8*tok_len +: 8] = b;
                end
                if (tok_len < LENGTH_MAX) begin
                    tok_len++;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            res[k].last = (k == n - 1);
            expected_tokens.push_back(res[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        tokenize_byte(b);
        if (b != BYTE_CR && b != BYTE_LF) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config();
        t_cfg_index idx;
        idx = idx.first();
        do begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                CFG_END_CHAR:      i_cfg_data <= 64'(end_char);
                CFG_CMD_SEP:       i_cfg_data <= 64'(cmd_sep);
                CFG_ARG_SEP:       i_cfg_data <= 64'(arg_sep);
                CFG_COMMAND_COUNT: i_cfg_data <= 64'(name_count);
                default:           i_cfg_data <= names[idx - CFG_NAME_0];
            endcase
            @(posedge i_clk);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        do begin
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(97, 122));
        end while (c == BYTE_CR || c == BYTE_LF || c == end_char || c == cmd_sep
                   || c == arg_sep);
        return c;
    endfunction

    function automatic logic [7:0] pick_marker();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(33, 64));
        endcase
    endfunction

    task automatic send_word(input bit as_command, input int max_len);
        logic [63:0] name;
        int          len;
        if (as_command && $urandom_range(0, 9) < 7) begin
            name = names[$urandom_range(0, 3)];
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, TEXT_BYTES) : TEXT_BYTES;
            for (int j = 0; j < len && name[8*j +: 8] != 8'd0; j++) begin
                send_byte(name[8*j +: 8]);
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(pick_char());
            end
        end else begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 75)
                                               : $urandom_range(0, max_len);
            repeat (len) send_byte(pick_char());
        end
    endtask

    task automatic send_transmission();
        int cmds;
        int args;
        cmds = $urandom_range(1, 4);
        for (int c = 0; c < cmds; c++) begin
            if (c != 0) begin
                send_byte(cmd_sep);
            end
            send_word(1'b1, 10);
            args = $urandom_range(0, 3);
            for (int a = 0; a < args; a++) begin
                send_byte(arg_sep);
                send_word(1'b0, 6);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            send_byte(end_char);
        end
    endtask

    task automatic test_default_config();
        send_text("go a b,st");
        send_byte(BYTE_LF);
        send_text("op");
        send_byte(BYTE_CR);
        send_text(";");
        wait_idle();
    endtask

    task automatic test_name_matching();
        names[0] = pack_name("read");
        names[1] = pack_name("write");
        names[2] = pack_name("ABCDEFGH");
        names[3] = pack_name("go");
        name_count = 3'd4;
        load_config();
        send_text("write 1  2,ABCDEFGHIJ,go;");
        send_text("read ;,, x;");
        send_text("go");
        send_byte(8'h00);
        send_text("x;");
        wait_idle();
    endtask

    task automatic test_marker_extremes();
        end_char = 8'hFF;
        cmd_sep = 8'h00;
        arg_sep = BYTE_CR;
        name_count = 3'd7;
        names[0] = '1;
        names[1] = '0;
        load_config();
        send_text("a");
        send_byte(8'h00);
        send_text("b");
        send_byte(BYTE_LF);
        send_text("c");
        send_byte(BYTE_CR);
        send_text("d");
        send_byte(8'hFF);
        wait_idle();
        // Terminator and both separators share one byte, so the terminator wins.
        end_char = 8'd44;
        cmd_sep = 8'd44;
        arg_sep = 8'd44;
        load_config();
        send_text("ab,");
        send_byte(8'h00);
        send_text("z,");
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int target;
        int phase_end;
        int len;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            end_char = pick_marker();
            cmd_sep = pick_marker();
            arg_sep = pick_marker();
            name_count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            for (int s = 0; s < 4; s++) begin
                names[s] = '0;
                case ($urandom_range(0, 7))
                    0: names[s] = '0;
                    1: names[s] = {$urandom, $urandom};
                    default: begin
                        len = $urandom_range(1, TEXT_BYTES);
                        for (int j = 0; j < len; j++) begin
                            names[s][8*j +: 8] = pick_char();
                        end
                    end
                endcase
            end
            load_config();
            phase_end = items_sent + $urandom_range(150, 350);
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 7))
                    0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                    1: send_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
                    default: send_transmission();
                endcase
            end
            wait_idle();
        end
    endtask

    task automatic compare_field(input string fname, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = t_kind'(m_axis_tuser);
            got.text = m_axis_tdata[POS_TEXT +: 64];
            got.length = m_axis_tdata[POS_LENGTH +: 7];
            got.found = m_axis_tdata[POS_FOUND];
            got.index = m_axis_tdata[POS_INDEX +: 2];
            got.dropped = m_axis_tdata[POS_DROPPED];
            got.last = m_axis_tlast;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_tokens.pop_front();
                compare_field("token_kind", 64'(want.kind), 64'(got.kind));
                compare_field("token_text", want.text, got.text);
                compare_field("token_length", 64'(want.length), 64'(got.length));
                compare_field("match_found", 64'(want.found), 64'(got.found));
                compare_field("match_index", 64'(want.index), 64'(got.index));
                compare_field("bytes_dropped", 64'(want.dropped), 64'(got.dropped));
                compare_field("last_of_run", 64'(want.last), 64'(got.last));
            end
        end
        if (rx_mode_left == 0) begin
            rx_mode <= t_stall'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_tick <= rx_tick + 4'd1;
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
            RX_QUARTER: m_axis_tready <= (rx_tick[1:0] == 2'd0);
            default:    m_axis_tready <= (rx_tick == 4'd0);
        endcase
    end

    initial begin
        end_char = RST_END_CHAR;
        cmd_sep = RST_CMD_SEP;
        arg_sep = RST_ARG_SEP;
        name_count = '0;
        for (int s = 0; s < 4; s++) begin
            names[s] = '0;
        end
        tok_text = '0;
        tok_len = '0;
        fill_used = 0;
        in_args = 1'b0;
        overflowed = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_name_matching();
        test_marker_extremes();
        test_random_traffic();
        wait_idle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== command_token_matcher_core.f =====
+incdir+sv
sv/ctm_pkg.sv
sv/ctm_tokenizer.sv
sv/ctm_result_queue.sv
sv/command_token_matcher_core.sv
sv/ctm_checker.sv
test/command_token_matcher_core_tb.sv
